### rtl/core/rrc_pkg.sv
// Shared constants, codes and types of the random replacement cache.
// Used by every module under rtl/core; depends on nothing else.
package rrc_pkg;

  localparam int CAPACITY   = 8;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CAP_W  = $clog2(CAPACITY + 1);

  localparam int KEY_PORT_W   = 16;
  localparam int VALUE_PORT_W = 32;
  localparam int SLOT_PORT_W  = 3;
  localparam int OCC_PORT_W   = 4;
  localparam int CAP_CFG_W    = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CAP_CFG_W-1:0] CAP_CFG_RESET = 4'd8;

  localparam int                  LFSR_W     = 16;
  localparam logic [LFSR_W-1:0]   LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0]   LFSR_RESET = 16'd44257;
  localparam int                  MOD_STEPS  = LFSR_W / 2;
  localparam int                  MOD_CNT_W  = $clog2(MOD_STEPS + 1);

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd1;

  typedef struct packed {
    logic              start;
    logic              commit;
    logic              load;
    logic [LFSR_W-1:0] seed;
  } victim_ctl_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } victim_sts_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] res;
    res = cur >> 1;
    if (cur[0]) begin
      res = res ^ LFSR_TAPS;
    end
    return res;
  endfunction

endpackage

### rtl/core/rrc_kv_mem.sv
// Key and value memories of the cache, one write port and one read port each.
// Depends on rrc_pkg for sizes.
module rrc_kv_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [rrc_pkg::SLOT_W-1:0]      waddr,
  input  logic [rrc_pkg::KEY_BITS-1:0]    wkey,
  input  logic [rrc_pkg::VALUE_BITS-1:0]  wval,
  input  logic [rrc_pkg::SLOT_W-1:0]      raddr,
  output logic [rrc_pkg::KEY_BITS-1:0]    rkey,
  output logic [rrc_pkg::VALUE_BITS-1:0]  rval
);
  import rrc_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

### rtl/core/rrc_victim.sv
// Victim choice: 16-bit Galois LFSR and a two-bit-per-cycle remainder unit.
// Depends on rrc_pkg for the LFSR constants and control types.
module rrc_victim (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrc_pkg::victim_ctl_t        ctl,
  input  logic [rrc_pkg::CAP_W-1:0]   cap,
  output rrc_pkg::victim_sts_t        sts
);
  import rrc_pkg::*;

  logic [LFSR_W-1:0]    lfsr_r;
  logic [LFSR_W-1:0]    div_r;
  logic [SLOT_W-1:0]    rem_r;
  logic [MOD_CNT_W-1:0] cnt_r;

  logic [SLOT_W:0]   cap_x;
  logic [SLOT_W:0]   t1;
  logic [SLOT_W:0]   t2;
  logic [SLOT_W-1:0] r1;
  logic [SLOT_W-1:0] r2;

  always_comb begin
    cap_x = (SLOT_W + 1)'(cap);
    t1    = {rem_r, div_r[LFSR_W-1]};
    r1    = (t1 >= cap_x) ? SLOT_W'(t1 - cap_x) : SLOT_W'(t1);
    t2    = {r1, div_r[LFSR_W-2]};
    r2    = (t2 >= cap_x) ? SLOT_W'(t2 - cap_x) : SLOT_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_RESET;
    end else if (ctl.load) begin
      lfsr_r <= ctl.seed;
    end else if (ctl.commit) begin
      lfsr_r <= lfsr_next(lfsr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= MOD_CNT_W'(MOD_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - MOD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      div_r <= lfsr_next(lfsr_r);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      div_r <= div_r << 2;
      rem_r <= r2;
    end
  end

  assign sts.done = (cnt_r == '0);
  assign sts.slot = rem_r;

endmodule

### rtl/core/random_replacement_cache.sv
// Top level of the fully associative cache with random replacement.
// Depends on rrc_pkg, rrc_kv_mem and rrc_victim.
//
// Usage:
//   cfg_*  : register writes (index 0 capacity in use, index 1 LFSR seed,
//            which also reloads the LFSR). Write only while the block is idle.
//   in_*   : one request per transfer, func 0 lookup, func 1 insert/update.
//   out_*  : one result per request, held in an output register.
// One request is worked on at a time. The key memory is read one slot per
// cycle, from slot 0 upward; the scan ends at the first match or at the
// last slot in use, and the result is then registered. An eviction also
// waits for the remainder unit, started at the input transfer. in_ready
// rises again in the same cycle as out_valid, when the result is registered.
// A stalled receiver holds the result; the next request is still taken and
// worked on, and waits before its own result until the register frees up.
// Reset clears all valid bits and the count, sets capacity to 8 and loads
// the LFSR with 44257; memory contents are not cleared.
module random_replacement_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [rrc_pkg::KEY_PORT_W-1:0]      in_lookup_key,
  input  logic [rrc_pkg::VALUE_PORT_W-1:0]    in_entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [rrc_pkg::VALUE_PORT_W-1:0]    out_read_value,
  output logic [rrc_pkg::SLOT_PORT_W-1:0]     out_slot_used,
  output logic                                out_evicted,
  output logic [rrc_pkg::OCC_PORT_W-1:0]      out_occupancy
);
  import rrc_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [CAP_CFG_W-1:0]  cap_cfg_r;
  logic                  func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CAP_W-1:0]      issue_idx_r;
  logic [SLOT_W-1:0]     cmp_idx_r;
  logic                  cmp_live_r;
  logic                  hit_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [CAPACITY-1:0]   valid_r;
  logic [CAP_W-1:0]      count_r;
  logic [CAP_W-1:0]      count_nxt;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [VALUE_PORT_W-1:0] out_read_value_r;
  logic [SLOT_PORT_W-1:0]  out_slot_used_r;
  logic                    out_evicted_r;
  logic [OCC_PORT_W-1:0]   out_occupancy_r;

  logic [CAP_W-1:0]      cap_eff;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_slot;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic                  key_match;
  logic                  scan_last;
  logic                  is_insert;
  logic                  fill_new;
  logic                  evict_need;
  logic                  resolve_go;
  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic                  issue_live;
  victim_ctl_t           vctl;
  victim_sts_t           vsts;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (int'(cap_cfg_r) > CAPACITY) begin
      cap_eff = CAP_W'(CAPACITY);
    end else begin
      cap_eff = CAP_W'(cap_cfg_r);
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i] && (i < int'(cap_eff))) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign issue_live = (issue_idx_r < cap_eff);
  assign key_match  = cmp_live_r && valid_r[cmp_idx_r] && (rkey == key_r);
  assign scan_last  = cmp_live_r && ((CAP_W'(cmp_idx_r) + CAP_W'(1)) == cap_eff);

  assign is_insert  = (func_r == FUNC_INSERT);
  assign fill_new   = is_insert && !hit_r && free_found;
  assign evict_need = is_insert && !hit_r && !free_found;
  assign resolve_go = (state_r == S_RESOLVE) && (!out_valid_r || out_ready) &&
                      (!evict_need || vsts.done);

  assign mem_we    = resolve_go && is_insert;
  assign mem_waddr = hit_r ? slot_r : (free_found ? free_slot : vsts.slot);
  assign count_nxt = count_r + CAP_W'(fill_new);

  assign vctl.start  = in_xfer;
  assign vctl.commit = resolve_go && evict_need;
  assign vctl.load   = cfg_xfer && (cfg_index == REG_SEED);
  assign vctl.seed   = LFSR_W'(cfg_data);

  rrc_kv_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (key_r),
    .wval  (val_r),
    .raddr (issue_idx_r[SLOT_W-1:0]),
    .rkey  (rkey),
    .rval  (rval)
  );

  rrc_victim u_victim (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (vctl),
    .cap   (cap_eff),
    .sts   (vsts)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match || scan_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (resolve_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cap_cfg_r  <= CAP_CFG_RESET;
      valid_r    <= '0;
      count_r    <= '0;
      cmp_live_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_xfer && (cfg_index == REG_CAPACITY)) begin
        cap_cfg_r <= CAP_CFG_W'(cfg_data);
      end
      if (in_xfer) begin
        cmp_live_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        cmp_live_r <= issue_live;
      end
      if (resolve_go && is_insert && !hit_r) begin
        valid_r[mem_waddr] <= 1'b1;
        count_r            <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r      <= in_func;
      key_r       <= KEY_BITS'(in_lookup_key);
      val_r       <= VALUE_BITS'(in_entry_value);
      issue_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      issue_idx_r <= issue_idx_r + CAP_W'(issue_live);
      cmp_idx_r   <= issue_idx_r[SLOT_W-1:0];
      if (key_match) begin
        hit_r  <= 1'b1;
        slot_r <= cmp_idx_r;
        rval_r <= rval;
      end else if (scan_last) begin
        hit_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resolve_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_go) begin
      out_hit_r        <= hit_r;
      out_read_value_r <= (!is_insert && hit_r) ? VALUE_PORT_W'(rval_r) : '0;
      out_slot_used_r  <= (!is_insert && !hit_r) ? '0 : SLOT_PORT_W'(mem_waddr);
      out_evicted_r    <= evict_need;
      out_occupancy_r  <= OCC_PORT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_slot_used  = out_slot_used_r;
  assign out_evicted    = out_evicted_r;
  assign out_occupancy  = out_occupancy_r;

endmodule
